FILE: src/cmfuv_pkg.sv
package cmfuv_pkg;

	localparam int COMPONENT_BITS = 16;
	localparam int FRACTION_BITS  = 16;

	// face codes
	localparam logic [2:0] FACE_PLUS_Y  = 3'd0;
	localparam logic [2:0] FACE_MINUS_X = 3'd1;
	localparam logic [2:0] FACE_MINUS_Y = 3'd2;
	localparam logic [2:0] FACE_PLUS_X  = 3'd3;
	localparam logic [2:0] FACE_PLUS_Z  = 3'd4;
	localparam logic [2:0] FACE_MINUS_Z = 3'd5;

	// atlas column of a face, in quarters of the width
	function automatic logic [1:0] tile_col(input logic [2:0] face);
		logic [1:0] col;
		unique case (face)
			FACE_PLUS_X:  col = 2'd0;
			FACE_MINUS_X: col = 2'd2;
			FACE_PLUS_Y:  col = 2'd3;
			FACE_MINUS_Y: col = 2'd1;
			default:      col = 2'd2;
		endcase
		return col;
	endfunction

	// atlas row of a face, in thirds of the height
	function automatic logic [1:0] tile_row(input logic [2:0] face);
		logic [1:0] row;
		unique case (face)
			FACE_PLUS_Z:  row = 2'd0;
			FACE_MINUS_Z: row = 2'd2;
			default:      row = 2'd1;
		endcase
		return row;
	endfunction

endpackage

FILE: src/cube_map_face_uv_top.sv
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------
// request   | in_valid / in_ready  | dir_x, dir_y, dir_z (signed)
// result    | out_valid / out_ready| face, tex_u, tex_v (Q1.F), zero_vector
//
// one request per cycle sustained while out_ready stays high; the pipe holds
// three setup stages, FRACTION_BITS + 2 restoring divide stages and one
// rounding/output stage, the divide depth set by the one-quotient-bit-per-stage divider
// arst_n clears every valid bit; payload registers are not reset
// each stage holds while the stage after it is full and stalled, so a
// bubble anywhere lets a request in; out_ready low with a full pipe stops
// in_ready, and nothing is dropped or repeated
module cube_map_face_uv_top #(
	parameter int COMPONENT_BITS = cmfuv_pkg::COMPONENT_BITS,
	parameter int FRACTION_BITS  = cmfuv_pkg::FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COMPONENT_BITS-1:0] dir_x,
	input  logic signed [COMPONENT_BITS-1:0] dir_y,
	input  logic signed [COMPONENT_BITS-1:0] dir_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       face,
	output logic [FRACTION_BITS:0]           tex_u,
	output logic [FRACTION_BITS:0]           tex_v,
	output logic                             zero_vector
);

	localparam int CB = COMPONENT_BITS;
	// remainder / numerator / divisor width: up to 8 * 2^(CB-1), and 2r < 2d
	localparam int RW = CB + 3;
	// quotient bits: floor(n * 2^(F+1) / d) with n <= d
	localparam int QW = FRACTION_BITS + 2;

	// ---------------- stage enables (ready chain, back to front) ----------------
	logic          vld_s1, vld_s2, vld_s3, vld_sf;
	logic [QW-1:0] vld_sd;
	logic          en_s1, en_s2, en_s3, en_sf;
	logic [QW-1:0] en_sd;

	assign en_sf = !vld_sf || out_ready;

	always_comb begin
		en_sd[QW-1] = !vld_sd[QW-1] || en_sf;
		for (int k = QW - 2; k >= 0; k--) begin
			en_sd[k] = !vld_sd[k] || en_sd[k+1];
		end
	end

	assign en_s3    = !vld_s3 || en_sd[0];
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// ---------------- stage 1: magnitudes, major axis, face ----------------
	logic [CB-1:0]        ax, ay, az;
	logic                 x_gt_y, x_gt_z, y_gt_z, all_zero;
	logic [2:0]           face_c;
	logic [CB-1:0]        m_c;
	logic signed [CB-1:0] a_c, b_c;

	assign ax = dir_x[CB-1] ? CB'(~dir_x + 1'b1) : dir_x;
	assign ay = dir_y[CB-1] ? CB'(~dir_y + 1'b1) : dir_y;
	assign az = dir_z[CB-1] ? CB'(~dir_z + 1'b1) : dir_z;

	assign x_gt_y   = ax > ay;
	assign x_gt_z   = ax > az;
	assign y_gt_z   = ay > az;
	assign all_zero = ~|{dir_x, dir_y, dir_z};

	always_comb begin
		priority if (x_gt_y && x_gt_z) begin
			face_c = dir_x[CB-1] ? cmfuv_pkg::FACE_MINUS_X : cmfuv_pkg::FACE_PLUS_X;
			m_c    = ax;
			a_c    = dir_y;
			b_c    = dir_z;
		end else if (!x_gt_y && y_gt_z) begin
			face_c = dir_y[CB-1] ? cmfuv_pkg::FACE_MINUS_Y : cmfuv_pkg::FACE_PLUS_Y;
			m_c    = ay;
			a_c    = dir_x;
			b_c    = dir_z;
		end else begin
			// ties with z fall to z, an x/y tie to y; zero vector uses a unit major so u, v land mid tile
			face_c = dir_z[CB-1] ? cmfuv_pkg::FACE_MINUS_Z : cmfuv_pkg::FACE_PLUS_Z;
			m_c    = all_zero ? CB'(1) : az;
			a_c    = dir_x;
			b_c    = dir_y;
		end
	end

	logic [2:0]           face_s1;
	logic [CB-1:0]        m_s1;
	logic signed [CB-1:0] a_s1, b_s1;
	logic                 zero_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			face_s1 <= face_c;
			m_s1    <= m_c;
			a_s1    <= a_c;
			b_s1    <= b_c;
			zero_s1 <= all_zero;
		end
	end

	// ---------------- stage 2: a + M, b + M, 2M, 6M ----------------
	logic [2:0]    face_s2;
	logic [RW-1:0] apm_s2, bpm_s2, m2_s2, m6_s2;
	logic          zero_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			face_s2 <= face_s1;
			zero_s2 <= zero_s1;
			apm_s2  <= {{(RW-CB){a_s1[CB-1]}}, a_s1} + RW'(m_s1);
			bpm_s2  <= {{(RW-CB){b_s1[CB-1]}}, b_s1} + RW'(m_s1);
			m2_s2   <= RW'({m_s1, 1'b0});
			m6_s2   <= RW'({m_s1, 2'b00}) + RW'({m_s1, 1'b0});
		end
	end

	// ---------------- stage 3: numerators and divisors ----------------
	// u = (a + M + 2kM) / 8M,  v = (b + M + 2jM) / 6M
	logic [1:0]    col_c, row_c;
	logic [RW-1:0] off_u, off_v;

	assign col_c = cmfuv_pkg::tile_col(face_s2);
	assign row_c = cmfuv_pkg::tile_row(face_s2);

	always_comb begin
		unique case (col_c)
			2'd0:    off_u = '0;
			2'd1:    off_u = m2_s2;
			2'd2:    off_u = {m2_s2[RW-2:0], 1'b0};
			default: off_u = m6_s2;
		endcase
		unique case (row_c)
			2'd0:    off_v = '0;
			2'd1:    off_v = m2_s2;
			default: off_v = {m2_s2[RW-2:0], 1'b0};
		endcase
	end

	logic [2:0]    face_s3;
	logic [RW-1:0] nu_s3, nv_s3, du_s3, dv_s3;
	logic          zero_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			face_s3 <= face_s2;
			zero_s3 <= zero_s2;
			nu_s3   <= apm_s2 + off_u;
			nv_s3   <= bpm_s2 + off_v;
			du_s3   <= {m2_s2[RW-3:0], 2'b00};
			dv_s3   <= m6_s2;
		end
	end

	// ---------------- divider stages: one quotient bit each ----------------
	// first stage decides the integer bit (n >= d), the rest shift and subtract
	logic [2:0]    face_sd [QW];
	logic          zero_sd [QW];
	logic [RW-1:0] ru_sd   [QW];
	logic [RW-1:0] rv_sd   [QW];
	logic [RW-1:0] du_sd   [QW];
	logic [RW-1:0] dv_sd   [QW];
	logic [QW-1:0] qu_sd   [QW];
	logic [QW-1:0] qv_sd   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [2:0]    face_in;
		logic          zero_in;
		logic [RW-1:0] tu, tv, du_in, dv_in;
		logic [QW-1:0] qu_in, qv_in;
		logic          ge_u, ge_v;

		if (k == 0) begin : g_first
			assign face_in = face_s3;
			assign zero_in = zero_s3;
			assign tu      = nu_s3;
			assign tv      = nv_s3;
			assign du_in   = du_s3;
			assign dv_in   = dv_s3;
			assign qu_in   = '0;
			assign qv_in   = '0;
		end else begin : g_next
			assign face_in = face_sd[k-1];
			assign zero_in = zero_sd[k-1];
			assign tu      = {ru_sd[k-1][RW-2:0], 1'b0};
			assign tv      = {rv_sd[k-1][RW-2:0], 1'b0};
			assign du_in   = du_sd[k-1];
			assign dv_in   = dv_sd[k-1];
			assign qu_in   = qu_sd[k-1];
			assign qv_in   = qv_sd[k-1];
		end

		assign ge_u = tu >= du_in;
		assign ge_v = tv >= dv_in;

		always_ff @(posedge clk) begin
			if (en_sd[k]) begin
				face_sd[k] <= face_in;
				zero_sd[k] <= zero_in;
				du_sd[k]   <= du_in;
				dv_sd[k]   <= dv_in;
				ru_sd[k]   <= ge_u ? (tu - du_in) : tu;
				rv_sd[k]   <= ge_v ? (tv - dv_in) : tv;
				qu_sd[k]   <= {qu_in[QW-2:0], ge_u};
				qv_sd[k]   <= {qv_in[QW-2:0], ge_v};
			end
		end
	end

	// ---------------- output stage: round half up ----------------
	// round(x) = floor((floor(2x) + 1) / 2)
	logic [QW-1:0]            qu_inc, qv_inc;
	logic [2:0]               face_sf;
	logic [FRACTION_BITS:0]   tex_u_sf, tex_v_sf;
	logic                     zero_sf;

	assign qu_inc = qu_sd[QW-1] + QW'(1);
	assign qv_inc = qv_sd[QW-1] + QW'(1);

	always_ff @(posedge clk) begin
		if (en_sf) begin
			face_sf  <= face_sd[QW-1];
			zero_sf  <= zero_sd[QW-1];
			tex_u_sf <= qu_inc[QW-1:1];
			tex_v_sf <= qv_inc[QW-1:1];
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_sd <= '0;
			vld_sf <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_sd[0]) vld_sd[0] <= vld_s3;
			for (int k = 1; k < QW; k++) begin
				if (en_sd[k]) vld_sd[k] <= vld_sd[k-1];
			end
			if (en_sf) vld_sf <= vld_sd[QW-1];
		end
	end

	assign out_valid   = vld_sf;
	assign face        = face_sf;
	assign tex_u       = tex_u_sf;
	assign tex_v       = tex_v_sf;
	assign zero_vector = zero_sf;

`ifndef SYNTHESIS
	// a zero direction always lands on +z
	a_zero_face: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> face == cmfuv_pkg::FACE_PLUS_Z)
		else $error("zero vector result not on +z face");

	// face code is one of the six faces
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face <= cmfuv_pkg::FACE_MINUS_Z)
		else $error("face code out of range");

	// coordinates never exceed 1.0
	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tex_u[FRACTION_BITS] && (|tex_u[FRACTION_BITS-1:0])))
		else $error("tex_u above 1.0");

	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tex_v[FRACTION_BITS] && (|tex_v[FRACTION_BITS-1:0])))
		else $error("tex_v above 1.0");
`endif

endmodule
